### rtl/zrbp_pkg.sv
package zrbp_pkg;

  localparam int NumBlocks  = 64;
  localparam int NumModels  = 8;
  localparam int NumRoles   = 4;
  localparam int CountBits  = 16;
  localparam int BlkW       = 6;
  localparam int LenW       = 7;
  localparam int CntEntries = NumModels * NumRoles;
  localparam int CntIdxW    = 5;
  localparam int RefsW      = 21;

  localparam logic [2:0] FuncAlloc   = 3'd0;
  localparam logic [2:0] FuncShare   = 3'd1;
  localparam logic [2:0] FuncRelease = 3'd2;
  localparam logic [2:0] FuncWrite   = 3'd3;
  localparam logic [2:0] FuncRead    = 3'd4;

  localparam logic [2:0] RegRateThreshold = 3'd0;
  localparam logic [2:0] RegInitBoundary  = 3'd1;
  localparam logic [2:0] RegMinHigh       = 3'd2;
  localparam logic [2:0] RegMaxHigh       = 3'd3;
  localparam logic [2:0] RegBorrowStep    = 3'd4;

  localparam logic [1:0] RoleProducer = 2'd0;
  localparam logic [1:0] RoleSharer   = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  block;
    logic [2:0]  model;
    logic [1:0]  role;
    logic [19:0] request_rate;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  granted_block;
    logic [6:0]  free_blocks;
    logic [6:0]  used_high;
    logic [6:0]  used_low;
    logic [6:0]  zone_boundary;
    logic        block_class;
    logic [20:0] block_refs;
  } rsp_t;

  // Control from the sequencer to the free-list chain.
  typedef struct packed {
    logic            rotate;
    logic            remove;
    logic [BlkW-1:0] remove_pos;
    logic            append;
    logic [BlkW-1:0] append_blk;
  } chain_ctl_t;

endpackage

### rtl/zrbp_cell.sv
module zrbp_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [zrbp_pkg::BlkW-1:0] reset_val_i,
  input  logic                 load_i,
  input  logic [zrbp_pkg::BlkW-1:0] load_val_i,
  output logic [zrbp_pkg::BlkW-1:0] entry_o
);
  import zrbp_pkg::*;

  logic [BlkW-1:0] entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= reset_val_i;
    end else if (load_i) begin
      entry_q <= load_val_i;
    end
  end

  assign entry_o = entry_q;
endmodule

### rtl/zrbp_chain.sv
module zrbp_chain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  zrbp_pkg::chain_ctl_t      ctl_i,
  input  logic [zrbp_pkg::LenW-1:0] len_i,
  output logic [zrbp_pkg::BlkW-1:0] head_o,
  output logic [zrbp_pkg::BlkW-1:0] last_o
);
  import zrbp_pkg::*;

  logic [BlkW-1:0] ent [NumBlocks];
  logic [BlkW-1:0] nxt [NumBlocks];
  logic            ld  [NumBlocks];

  // Rotate moves every cell one place towards the head, the head going to the tail.
  // Remove shifts cells above the position down; append writes the slot at len.
  for (genvar g = 0; g < NumBlocks; g++) begin : g_cell
    always_comb begin
      ld[g]  = 1'b0;
      nxt[g] = ent[g];
      if (ctl_i.rotate) begin
        ld[g]  = 1'b1;
        nxt[g] = ent[(g + 1) % NumBlocks];
      end else if (ctl_i.remove) begin
        ld[g]  = (BlkW'(g) >= ctl_i.remove_pos) && (g < NumBlocks - 1);
        nxt[g] = ent[(g + 1) % NumBlocks];
      end else if (ctl_i.append) begin
        ld[g]  = (LenW'(g) == len_i);
        nxt[g] = ctl_i.append_blk;
      end
    end

    zrbp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .reset_val_i(BlkW'(g)),
      .load_i     (ld[g]),
      .load_val_i (nxt[g]),
      .entry_o    (ent[g])
    );
  end

  assign head_o = ent[0];
  assign last_o = ent[len_i[BlkW-1:0] - 1'b1];
endmodule

### rtl/zoned_refcount_block_pool.sv
// Block pool with an ordered free list kept in a chain of 64 cells. An allocate
// rotates the whole free list through the chain head once per search (and makes a
// second pass when a high-class request finds no block in its zone), then closes
// the gap. A release that decrements a counter walks the 32 counters of its block,
// and clears them when the block is freed. Every reply ends with a sum of the
// named block's counters. busy_o stays high from when a request is taken until
// the result appears, and the result appears in the same cycle that busy_o falls.
// After reset the counter memory, all 2048 entries, is cleared, during which
// busy_o stays high. Results cannot be stalled: each appears for one cycle with
// done_o.
module zoned_refcount_block_pool (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  zrbp_pkg::req_t    req_i,
  output logic              done_o,
  output zrbp_pkg::rsp_t    rsp_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [19:0]       cfg_data_i
);
  import zrbp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SCAN2, S_TAKE, S_RD, S_WR,
    S_RELSUM, S_FREE, S_SUM, S_SUMLAST, S_OUT
  } state_e;

  state_e state_q;
  logic [19:0] thr_q;
  logic [6:0]  minh_q, maxh_q, step_q;
  logic [6:0]  bnd_q, len_q, hused_q, lused_q;
  logic [NumBlocks-1:0] alloc_q, class_q;
  req_t        req_q;
  logic [7:0]  cnt_q;
  logic        found_q, high_q, stat_q;
  logic [BlkW-1:0] pos_q, named_q, gnt_q;
  logic        named_ok_q;
  logic [RefsW-1:0] sum_q;
  logic [10:0] clr_q;
  rsp_t        rsp_q;
  logic        done_q;

  logic [CountBits-1:0] mem [NumBlocks*CntEntries];
  logic [10:0]          mem_addr;
  logic                 mem_we;
  logic [CountBits-1:0] mem_wd, mem_rd_q;

  chain_ctl_t      ctl;
  logic [BlkW-1:0] head, last;

  zrbp_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .len_i (len_q),
    .head_o(head),
    .last_o(last)
  );

  function automatic logic [6:0] clamp_bnd(logic [6:0] b, logic [6:0] mn, logic [6:0] mx);
    logic signed [8:0] v, lo, hi;
    v  = {2'b00, b};
    lo = 9'sd64 - {2'b00, mx};
    hi = 9'sd64 - {2'b00, mn};
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    if (v > 9'sd64) v = 9'sd64;
    return v[6:0];
  endfunction

  logic [7:0] cur_hi, tgt;
  assign cur_hi = 8'd64 - {1'b0, bnd_q};
  always_comb begin
    tgt = cur_hi + {1'b0, step_q};
    if (tgt > {1'b0, maxh_q}) tgt = {1'b0, maxh_q};
    if (tgt > 8'd64) tgt = 8'd64;
  end

  logic head_high, in_list;
  assign head_high  = {1'b0, head} >= bnd_q;
  assign in_list    = {1'b0, cnt_q[5:0]} < len_q && !cnt_q[6];

  // Counter memory port.
  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = '0;
    mem_addr = {req_q.block[5:0], cnt_q[4:0]};
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1; mem_addr = clr_q;
      end
      S_RD: mem_addr = {req_q.block[5:0], req_q.model,
                        (req_q.func == FuncShare) ? RoleSharer : req_q.role};
      S_WR: begin
        mem_addr = {req_q.block[5:0], req_q.model,
                    (req_q.func == FuncShare) ? RoleSharer : req_q.role};
        if (req_q.func == FuncAlloc) begin
          mem_we   = 1'b1;
          mem_addr = {gnt_q, req_q.model, RoleProducer};
          mem_wd   = CountBits'(1);
        end else if (req_q.func == FuncShare) begin
          mem_we = (mem_rd_q != '1);
          mem_wd = mem_rd_q + 1'b1;
        end else begin
          mem_we = (mem_rd_q != '0);
          mem_wd = mem_rd_q - 1'b1;
        end
      end
      S_FREE: begin
        mem_we = 1'b1; mem_addr = {req_q.block[5:0], cnt_q[4:0]};
      end
      S_RELSUM, S_SUM: mem_addr = {named_q, cnt_q[4:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_q <= mem[mem_addr];
  end

  always_comb begin
    ctl = '0;
    if ((state_q == S_SCAN || state_q == S_SCAN2) && !cnt_q[6]) ctl.rotate = 1'b1;
    if (state_q == S_TAKE) begin
      ctl.remove = 1'b1; ctl.remove_pos = pos_q;
    end
    if (state_q == S_FREE && cnt_q[4:0] == 5'd31 && len_q < 7'(NumBlocks)) begin
      ctl.append = 1'b1; ctl.append_blk = req_q.block[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      thr_q <= 20'd10; minh_q <= 7'd6; maxh_q <= 7'd32; step_q <= 7'd2;
      bnd_q <= 7'd52; len_q <= 7'(NumBlocks); hused_q <= '0; lused_q <= '0;
      alloc_q <= '0; class_q <= '0; clr_q <= '0; done_q <= 1'b0;
      cnt_q <= '0; found_q <= 1'b0; high_q <= 1'b0; stat_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegRateThreshold: thr_q <= cfg_data_i;
          RegInitBoundary: begin
            bnd_q   <= clamp_bnd(cfg_data_i[6:0], minh_q, maxh_q);
          end
          RegMinHigh:    minh_q <= cfg_data_i[6:0];
          RegMaxHigh:    maxh_q <= cfg_data_i[6:0];
          RegBorrowStep: step_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == 11'h7ff) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            req_q <= req_i; cnt_q <= '0; found_q <= 1'b0; stat_q <= 1'b1;
            high_q <= req_i.request_rate > thr_q;
            named_q <= req_i.block[5:0];
            named_ok_q <= req_i.block < 8'(NumBlocks);
            gnt_q <= '0;
            unique case (req_i.func)
              FuncAlloc: state_q <= (len_q != 0) ? S_SCAN : S_SUM;
              FuncShare, FuncRelease:
                state_q <= (req_i.block < 8'(NumBlocks)) ? S_RD : S_SUM;
              FuncWrite: begin
                stat_q <= !(req_i.block < 8'(NumBlocks) && alloc_q[req_i.block[5:0]]);
                state_q <= S_SUM;
              end
              FuncRead: begin
                stat_q <= !(req_i.block < 8'(NumBlocks)); state_q <= S_SUM;
              end
              default: state_q <= S_SUM;
            endcase
          end
        end
        S_SCAN, S_SCAN2: begin
          if (!cnt_q[6]) begin
            if (in_list && !found_q && head_high == (state_q == S_SCAN2 ? 1'b1 : high_q)) begin
              found_q <= 1'b1; pos_q <= cnt_q[5:0]; gnt_q <= head;
            end
            cnt_q <= cnt_q + 1'b1;
          end else begin
            cnt_q <= '0;
            if (found_q) state_q <= S_TAKE;
            else if (state_q == S_SCAN && high_q) begin
              if (cur_hi < {1'b0, maxh_q}) bnd_q <= 7'(8'd64 - tgt);
              state_q <= S_SCAN2;
            end else begin
              pos_q <= 6'(len_q - 1'b1); gnt_q <= last; state_q <= S_TAKE;
            end
          end
        end
        S_TAKE: begin
          len_q <= len_q - 1'b1;
          alloc_q[gnt_q] <= 1'b1; class_q[gnt_q] <= high_q;
          if (high_q) hused_q <= hused_q + 1'b1; else lused_q <= lused_q + 1'b1;
          named_q <= gnt_q; named_ok_q <= 1'b1; stat_q <= 1'b0;
          state_q <= S_WR;
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          cnt_q <= '0; sum_q <= '0;
          if (req_q.func == FuncAlloc) state_q <= S_SUM;
          else if (req_q.func == FuncShare) begin
            stat_q <= (mem_rd_q == '1);
            state_q <= S_SUM;
          end else if (mem_rd_q == '0) state_q <= S_SUM;
          else begin
            stat_q <= 1'b0; state_q <= S_RELSUM;
          end
        end
        S_RELSUM: begin
          if (cnt_q != 0) sum_q <= sum_q + RefsW'(mem_rd_q);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 8'd32) begin
            cnt_q <= '0;
            if (sum_q + RefsW'(mem_rd_q) == 0 && alloc_q[req_q.block[5:0]])
              state_q <= S_FREE;
            else state_q <= S_SUM;
          end
        end
        S_FREE: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[4:0] == 5'd31) begin
            cnt_q <= '0;
            alloc_q[req_q.block[5:0]] <= 1'b0;
            if (len_q < 7'(NumBlocks)) len_q <= len_q + 1'b1;
            if (class_q[req_q.block[5:0]]) begin
              if (hused_q != 0) hused_q <= hused_q - 1'b1;
            end else if (lused_q != 0) lused_q <= lused_q - 1'b1;
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt_q == 0) sum_q <= '0;
          else sum_q <= sum_q + RefsW'(mem_rd_q);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 8'd32) state_q <= S_SUMLAST;
        end
        S_SUMLAST: state_q <= S_OUT;
        S_OUT: begin
          done_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      rsp_q.status        <= stat_q;
      rsp_q.granted_block <= stat_q ? '0 : gnt_q;
      rsp_q.free_blocks   <= len_q;
      rsp_q.used_high     <= hused_q;
      rsp_q.used_low      <= lused_q;
      rsp_q.zone_boundary <= bnd_q;
      rsp_q.block_class   <= named_ok_q & class_q[named_q];
      rsp_q.block_refs    <= named_ok_q ? sum_q : '0;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= 7'(NumBlocks))
    else $error("free list overflow");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    8'(hused_q) + 8'(lused_q) + 8'(len_q) == 8'(NumBlocks))
    else $error("block accounting broken");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_o)
    else $error("result while busy");
endmodule

### bench/zoned_refcount_block_pool_tb.sv
`timescale 1ns / 100ps

module zoned_refcount_block_pool_tb;
  import zrbp_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;

  zoned_refcount_block_pool u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Pool shadow state.
  int unsigned thr_q, ib_q, minh_q, maxh_q, step_q;
  bit          alloc_q [NumBlocks];
  bit          cls_q [NumBlocks];
  int unsigned cnt_q [NumBlocks][NumModels][NumRoles];
  int unsigned order_q [NumBlocks];
  int unsigned flen_q, hused_q, lused_q;
  int          bnd_q;

  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int unsigned errors = 0;
  int unsigned n_reqs = 0, n_rsps = 0, n_allocs = 0, n_frees = 0, n_borrows = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;
  int unsigned gap_left = 0, burst_left = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void enqueue(input req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic void load_boundary();
    int b, lo, hi;
    b  = ib_q;
    lo = NumBlocks - int'(maxh_q);
    hi = NumBlocks - int'(minh_q);
    if (b < lo) b = lo;
    if (b > hi) b = hi;
    if (b < 0) b = 0;
    if (b > NumBlocks) b = NumBlocks;
    bnd_q = b;
  endfunction

  function automatic void pool_reset();
    thr_q = 10; ib_q = 52; minh_q = 6; maxh_q = 32; step_q = 2;
    for (int i = 0; i < NumBlocks; i++) begin
      alloc_q[i] = 0; cls_q[i] = 0; order_q[i] = i;
      for (int m = 0; m < NumModels; m++)
        for (int r = 0; r < NumRoles; r++) cnt_q[i][m][r] = 0;
    end
    flen_q = NumBlocks; hused_q = 0; lused_q = 0;
    load_boundary();
  endfunction

  function automatic longint unsigned block_total(input int unsigned b);
    longint unsigned s;
    s = 0;
    for (int m = 0; m < NumModels; m++)
      for (int r = 0; r < NumRoles; r++) s += cnt_q[b][m][r];
    return s;
  endfunction

  function automatic int find_zone(input bit high);
    for (int i = 0; i < int'(flen_q); i++)
      if ((int'(order_q[i]) >= bnd_q) == high) return i;
    return -1;
  endfunction

  function automatic rsp_t pool_predict(input req_t rq);
    rsp_t        o;
    bit          bok, ok, high;
    int          pos, cur, tgt;
    int unsigned nb, b;
    bok = rq.block < NumBlocks;
    nb  = rq.block;
    ok  = bok;
    o   = '0;
    o.status = 1'b1;
    case (rq.func)
      FuncAlloc: begin
        if (flen_q > 0) begin
          high = rq.request_rate > thr_q;
          pos = find_zone(high);
          if (pos < 0 && high) begin
            cur = NumBlocks - bnd_q;
            if (cur < int'(maxh_q)) begin
              tgt = cur + int'(step_q);
              if (tgt > int'(maxh_q)) tgt = int'(maxh_q);
              if (tgt > NumBlocks) tgt = NumBlocks;
              bnd_q = NumBlocks - tgt;
              n_borrows++;
            end
            pos = find_zone(1'b1);
          end
          if (pos < 0) pos = int'(flen_q) - 1;
          b = order_q[pos];
          for (int i = pos; i + 1 < int'(flen_q); i++) order_q[i] = order_q[i+1];
          flen_q--;
          alloc_q[b] = 1; cls_q[b] = high;
          cnt_q[b][rq.model][RoleProducer] = 1;
          if (high) hused_q++; else lused_q++;
          o.status = 1'b0; o.granted_block = 6'(b);
          nb = b; ok = 1; n_allocs++;
        end
      end
      FuncShare: begin
        if (bok && cnt_q[rq.block][rq.model][RoleSharer] < 65535) begin
          cnt_q[rq.block][rq.model][RoleSharer]++;
          o.status = 1'b0;
        end
      end
      FuncRelease: begin
        if (bok && cnt_q[rq.block][rq.model][rq.role] != 0) begin
          cnt_q[rq.block][rq.model][rq.role]--;
          if (block_total(rq.block) == 0 && alloc_q[rq.block]) begin
            alloc_q[rq.block] = 0;
            if (flen_q < NumBlocks) begin
              order_q[flen_q] = rq.block; flen_q++;
            end
            if (cls_q[rq.block]) begin
              if (hused_q > 0) hused_q--;
            end else if (lused_q > 0) lused_q--;
            n_frees++;
          end
          o.status = 1'b0;
        end
      end
      FuncWrite: if (bok && alloc_q[rq.block]) o.status = 1'b0;
      FuncRead:  if (bok) o.status = 1'b0;
      default: ;
    endcase
    o.free_blocks   = 7'(flen_q);
    o.used_high     = 7'(hused_q);
    o.used_low      = 7'(lused_q);
    o.zone_boundary = 7'(bnd_q);
    o.block_class   = ok && cls_q[nb];
    o.block_refs    = ok ? 21'(block_total(nb)) : '0;
    return o;
  endfunction

  // Driver: bursts with random gaps; a request is taken when start and not busy.
  always @(negedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      if (pending_reqs.size() == 0 || hold_off || burst_left == 0) begin
        start_i <= 1'b0;
      end else begin
        req_i <= pending_reqs[0];
        void'(pending_reqs.pop_front());
        burst_left--;
      end
    end else if (rst_ni && !start_i) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0 && !hold_off) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 90);
        end
        if (gap_left == 0) begin
          req_i   <= pending_reqs[0];
          void'(pending_reqs.pop_front());
          start_i <= 1'b1;
          burst_left--;
        end
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    rsp_t want;
    bit   act;
    if (rst_ni) begin
      act = 1'b0;
      if (start_i && !busy_o) begin
        expected_rsps.insert(expected_rsps.size(), pool_predict(req_i));
        n_reqs++;
        act = 1'b1;
      end
      if (done_o) begin
        act = 1'b1;
        n_rsps++;
        if (expected_rsps.size() == 0) begin
          report("unexpected response", 0, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_o.status != want.status) report("status", rsp_o.status, want.status);
          if (rsp_o.granted_block != want.granted_block)
            report("granted_block", rsp_o.granted_block, want.granted_block);
          if (rsp_o.free_blocks != want.free_blocks)
            report("free_blocks", rsp_o.free_blocks, want.free_blocks);
          if (rsp_o.used_high != want.used_high)
            report("used_high", rsp_o.used_high, want.used_high);
          if (rsp_o.used_low != want.used_low)
            report("used_low", rsp_o.used_low, want.used_low);
          if (rsp_o.zone_boundary != want.zone_boundary)
            report("zone_boundary", rsp_o.zone_boundary, want.zone_boundary);
          if (rsp_o.block_class != want.block_class)
            report("block_class", rsp_o.block_class, want.block_class);
          if (rsp_o.block_refs != want.block_refs)
            report("block_refs", rsp_o.block_refs, want.block_refs);
        end
      end
      idle_cycles <= act ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
        $display("zoned_refcount_block_pool_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic req_t mk(input logic [2:0] f, input logic [7:0] b, input logic [2:0] m,
                              input logic [1:0] r, input logic [19:0] rate);
    req_t q;
    q.func = f; q.block = b; q.model = m; q.role = r; q.request_rate = rate;
    return q;
  endfunction

  // Mostly meaningful traffic on in-range blocks, with some noise.
  function automatic req_t rand_req();
    logic [2:0] f;
    logic [7:0] b;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30) f = FuncAlloc;
    else if (k < 50) f = FuncShare;
    else if (k < 80) f = FuncRelease;
    else if (k < 88) f = FuncWrite;
    else if (k < 96) f = FuncRead;
    else f = 3'($urandom_range(0, 7));
    b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NumBlocks - 1));
    return mk(f, b, 3'($urandom), ($urandom_range(0, 2) != 0) ? RoleProducer : 2'($urandom),
              ($urandom_range(0, 1) != 0) ? 20'($urandom_range(0, 20)) : 20'($urandom));
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRateThreshold: thr_q = val;
      RegInitBoundary: begin ib_q = val[6:0]; load_boundary(); end
      RegMinHigh: minh_q = val[6:0];
      RegMaxHigh: maxh_q = val[6:0];
      RegBorrowStep: step_q = val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) enqueue(rand_req());
    drain();
  endtask

  initial begin
    pool_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests.
    enqueue(mk(FuncRead, 8'd0, 3'd0, 2'd0, 20'd0));
    enqueue(mk(FuncAlloc, 8'd0, 3'd0, 2'd0, 20'd0));
    enqueue(mk(FuncAlloc, 8'd0, 3'd7, 2'd0, 20'hFFFFF));
    enqueue(mk(FuncShare, 8'd0, 3'd7, 2'd0, 20'd0));
    enqueue(mk(FuncShare, 8'hFF, 3'd1, 2'd0, 20'd0));
    enqueue(mk(FuncWrite, 8'd0, 3'd0, 2'd0, 20'd0));
    enqueue(mk(FuncWrite, 8'd5, 3'd0, 2'd0, 20'd0));
    enqueue(mk(FuncWrite, 8'd64, 3'd0, 2'd0, 20'd0));
    enqueue(mk(FuncRelease, 8'd0, 3'd0, 2'd3, 20'd0));
    enqueue(mk(FuncRelease, 8'd0, 3'd7, RoleSharer, 20'd0));
    enqueue(mk(FuncRelease, 8'd0, 3'd0, RoleProducer, 20'd0));
    enqueue(mk(FuncShare, 8'd9, 3'd2, 2'd0, 20'd0));
    enqueue(mk(FuncRelease, 8'd9, 3'd2, RoleSharer, 20'd0));
    enqueue(mk(FuncRead, 8'd63, 3'd0, 2'd0, 20'd0));
    enqueue(mk(FuncRead, 8'd200, 3'd0, 2'd0, 20'd0));
    enqueue(mk(3'd5, 8'd0, 3'd0, 2'd0, 20'd0));
    enqueue(mk(3'd7, 8'hFF, 3'd7, 2'd3, 20'hFFFFF));
    enqueue(mk(FuncAlloc, 8'd0, 3'd3, 2'd0, 20'd10));
    enqueue(mk(FuncAlloc, 8'd0, 3'd3, 2'd0, 20'd11));
    drain();

    // Pause until the pool is quiet, then exhaust it with high-class requests.
    hold_off = 1'b1;
    drain();
    hold_off = 1'b0;
    for (int i = 0; i < 70; i++)
      enqueue(mk(FuncAlloc, 8'd0, 3'($urandom), 2'd0, 20'hFFFFF));
    drain();
    run_phase(250);

    cfg_write(RegRateThreshold, 20'd0);
    cfg_write(RegMinHigh, 20'd0);
    cfg_write(RegMaxHigh, 20'd64);
    cfg_write(RegBorrowStep, 20'd64);
    cfg_write(RegInitBoundary, 20'd64);
    run_phase(250);

    cfg_write(RegRateThreshold, 20'hFFFFF);
    cfg_write(RegMinHigh, 20'd64);
    cfg_write(RegMaxHigh, 20'd0);
    cfg_write(RegBorrowStep, 20'd0);
    cfg_write(RegInitBoundary, 20'd0);
    run_phase(200);

    cfg_write(RegRateThreshold, 20'd10);
    cfg_write(RegMinHigh, 20'd2);
    cfg_write(RegMaxHigh, 20'd40);
    cfg_write(RegBorrowStep, 20'd1);
    cfg_write(RegInitBoundary, 20'd127);
    run_phase(300);

    cfg_write(RegMaxHigh, 20'd20);
    cfg_write(RegBorrowStep, 20'd5);
    cfg_write(RegInitBoundary, 20'd30);
    run_phase(300);

    $display("covered %0d requests and %0d responses: %0d allocations, %0d frees, %0d borrows",
             n_reqs, n_rsps, n_allocs, n_frees, n_borrows);
    if (errors == 0) begin
      $display("zoned_refcount_block_pool_tb: done, clean");
    end else begin
      $display("zoned_refcount_block_pool_tb: done, errors");
    end
    $finish;
  end
endmodule
